>>> hdl/cct_pkg.sv
`default_nettype none

package cct_pkg;

   // Limits of the time fields
   localparam logic [5:0]  SECOND_LAST = 6'd59;
   localparam logic [5:0]  MINUTE_LAST = 6'd59;
   localparam logic [4:0]  HOUR_LAST   = 5'd23;
   localparam logic [4:0]  DAY_FIRST  = 5'd1;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [15:0] YEAR_FIRST  = 16'd1000;

   // Month lengths
   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_FEB   = 5'd28;
   localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

   // Exact divisibility of a 16-bit value: multiply by the inverse modulo 2^16
   // and compare against floor((2^16 - 1) / divisor).
   localparam logic [15:0] INV_25       = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT  = 16'd2621;
   localparam logic [15:0] INV_125      = 16'd30933;
   localparam logic [15:0] DIV125_LIMIT = 16'd524;

   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SEC   = 3'd1,
      ST_BAD_MIN   = 3'd2,
      ST_BAD_HOUR  = 3'd3,
      ST_BAD_DAY   = 3'd4,
      ST_BAD_MONTH = 3'd5,
      ST_BAD_YEAR  = 3'd6,
      ST_DAY_RANGE = 3'd7
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  set_second;
      logic [5:0]  set_minute;
      logic [4:0]  set_hour;
      logic [4:0]  set_day;
      logic [3:0]  set_month;
      logic [15:0] set_year;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  cur_second;
      logic [5:0]  cur_minute;
      logic [4:0]  cur_hour;
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [15:0] cur_year;
      logic        leap;
   } rsp_type;

   // Leap rule: by 4, except by 100, unless by 400, except by 4000
   function automatic logic is_leap(logic [15:0] year);
      logic [31:0] prod25;
      logic [31:0] prod125;
      logic        div4;
      logic        div16;
      logic        div32;
      logic        div25;
      logic        div125;
      prod25  = 32'(year) * 32'(INV_25);
      prod125 = 32'(year) * 32'(INV_125);
      div4    = (year[1:0] == 2'd0);
      div16   = (year[3:0] == 4'd0);
      div32   = (year[4:0] == 5'd0);
      div25   = (prod25[15:0] <= DIV25_LIMIT);
      div125  = (prod125[15:0] <= DIV125_LIMIT);
      return div4 && (!div25 || (div16 && !(div32 && div125)));
   endfunction

   function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
      logic [4:0] days;
      unique case (month)
         4'd2:    days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   days = DAYS_SHORT;
         default: days = DAYS_LONG;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

>>> hdl/cct_if.sv
`default_nettype none

interface cct_req_if;
   import cct_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cct_rsp_if;
   import cct_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/calendar_clock_tick_top.sv
// A result is registered in the output register, or in skid if the output is held.
// Throughput: one beat per cycle while the skid register is empty; the two-entry
//   result buffer (output and skid registers) takes a request while one result waits.
// Reset (synchronous, active high): time 00:00:00, day 1, month 1, year 1000;
//   both result entries empty.
`default_nettype none

module calendar_clock_tick_top (
   input  wire logic clock,
   input  wire logic reset,
   cct_req_if.sink   req_bus,
   cct_rsp_if.source rsp_bus
);
   import cct_pkg::*;

   // Calendar state
   logic [5:0]  second_ff, second_in;
   logic [5:0]  minute_ff, minute_in;
   logic [4:0]  hour_ff, hour_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [15:0] year_ff, year_in;
   logic        leap_ff, leap_in;

   // Result buffer: output register and skid register
   logic    out_valid_ff;
   rsp_type out_ff;
   logic    skid_valid_ff;
   rsp_type skid_ff;

   logic       accept;
   logic       pop;
   status_type status;
   rsp_type    result;

   // Tick helpers
   logic [15:0] year_next;
   logic        leap_year_next;
   logic [4:0]  cur_month_len;

   // Set checks
   logic        set_leap;
   logic [4:0]  set_month_len;

   // Take a new beat whenever the skid register is free
   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = out_valid_ff && rsp_bus.ready;

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;

   assign year_next      = year_ff + 16'd1;
   assign leap_year_next = is_leap(year_next);
   assign cur_month_len  = month_days(month_ff, leap_ff);

   assign set_leap      = is_leap(req_bus.data.set_year);
   assign set_month_len = month_days(req_bus.data.set_month, set_leap);

   // Next calendar state and status for the incoming beat
   always_comb begin
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      leap_in   = leap_ff;
      status    = ST_OK;

      if (req_bus.data.cmd == CMD_SET) begin
         // Check in fixed order; report the first failure, load only if all pass
         priority if (req_bus.data.set_second > SECOND_LAST) begin
            status = ST_BAD_SEC;
         end else if (req_bus.data.set_minute > MINUTE_LAST) begin
            status = ST_BAD_MIN;
         end else if (req_bus.data.set_hour > HOUR_LAST) begin
            status = ST_BAD_HOUR;
         end else if (req_bus.data.set_day < DAY_FIRST) begin
            status = ST_BAD_DAY;
         end else if ((req_bus.data.set_month < MONTH_FIRST) ||
                      (req_bus.data.set_month > MONTH_LAST)) begin
            status = ST_BAD_MONTH;
         end else if (req_bus.data.set_year < YEAR_FIRST) begin
            status = ST_BAD_YEAR;
         end else if (req_bus.data.set_day > set_month_len) begin
            status = ST_DAY_RANGE;
         end else begin
            second_in = req_bus.data.set_second;
            minute_in = req_bus.data.set_minute;
            hour_in   = req_bus.data.set_hour;
            day_in    = req_bus.data.set_day;
            month_in  = req_bus.data.set_month;
            year_in   = req_bus.data.set_year;
            leap_in   = set_leap;
         end
      end else begin
         // One-second tick: carry through the chain; the year wraps at 16 bits
         if (second_ff < SECOND_LAST) begin
            second_in = second_ff + 6'd1;
         end else begin
            second_in = '0;
            if (minute_ff < MINUTE_LAST) begin
               minute_in = minute_ff + 6'd1;
            end else begin
               minute_in = '0;
               if (hour_ff < HOUR_LAST) begin
                  hour_in = hour_ff + 5'd1;
               end else begin
                  hour_in = '0;
                  if (day_ff < cur_month_len) begin
                     day_in = day_ff + 5'd1;
                  end else begin
                     day_in = DAY_FIRST;
                     if (month_ff < MONTH_LAST) begin
                        month_in = month_ff + 4'd1;
                     end else begin
                        month_in = MONTH_FIRST;
                        year_in  = year_next;
                        leap_in  = leap_year_next;
                     end
                  end
               end
            end
         end
      end

      result.status     = status;
      result.cur_second = second_in;
      result.cur_minute = minute_in;
      result.cur_hour   = hour_in;
      result.cur_day    = day_in;
      result.cur_month  = month_in;
      result.cur_year   = year_in;
      result.leap       = leap_in;
   end

   // Calendar registers; advance only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= '0;
         minute_ff <= '0;
         hour_ff   <= '0;
         day_ff    <= DAY_FIRST;
         month_ff  <= MONTH_FIRST;
         year_ff   <= YEAR_FIRST;
         leap_ff   <= 1'b0;
      end else if (accept) begin
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
         leap_ff   <= leap_in;
      end
   end

   // Result buffer control: refill the output from skid first, else from the new beat
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= accept;
         end else begin
            out_valid_ff  <= accept;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         // Output held by the sink: park the new result in skid
         skid_valid_ff <= 1'b1;
      end
   end

   // Result buffer payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

endmodule

`default_nettype wire
